// ----- hw/rtl/bst_pkg.sv -----
// shared constants, action codes and entry ram request type for the bounded set table
// no dependencies; imported by every module of the block
package bst_pkg;

  localparam int CAPACITY       = 16;
  localparam int ITEM_BITS      = 32;
  localparam int VALUE_BITS     = 32;
  localparam int ACTION_BITS    = 2;
  localparam int COUNT_OUT_BITS = 5;

  // stored key is the value masked to the item width
  localparam int KEY_BITS = (ITEM_BITS < VALUE_BITS) ? ITEM_BITS : VALUE_BITS;
  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TEST   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // one write port and one read port of the entry ram
  typedef struct packed {
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic [IDX_BITS-1:0] rd_addr;
  } ram_req_t;

endpackage

// ----- hw/rtl/bst_entry_ram.sv -----
// entry storage of the bounded set table: one write port, one registered read port
// depends on bst_pkg for widths and the request struct
module bst_entry_ram (
  input  logic                         clk,
  input  bst_pkg::ram_req_t            req,
  output logic [bst_pkg::KEY_BITS-1:0] rd_data
);
  import bst_pkg::*;

  logic [KEY_BITS-1:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule

// ----- hw/rtl/bounded_set_table.sv -----
// bounded set table top level: sequencer over the entry ram, fill count and result register
// depends on bst_pkg and bst_entry_ram
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   item     | item_valid / item_ready     | action, value
//   result   | result_valid / result_ready | ok, entry_count, is_empty
//
// clear goes from transfer straight to the result state; add, remove and test first search
// the entries held; a remove that hits any entry but the last then moves the last entry there.
// the search reads one entry per cycle through the single read port of the entry ram.
// rst clears the fill count and control state; the entry ram has no reset and needs none.
// a new item is taken while a finished result still waits; the next result then holds
// until the result register is free.
module bounded_set_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic [bst_pkg::ACTION_BITS-1:0]    action,
  input  logic [bst_pkg::VALUE_BITS-1:0]     value,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic                               ok,
  output logic [bst_pkg::COUNT_OUT_BITS-1:0] entry_count,
  output logic                               is_empty
);
  import bst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SEARCH  = 5'b00010,
    S_MOVE_RD = 5'b00100,
    S_MOVE_WR = 5'b01000,
    S_RESULT  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] fill_count, fill_count_next;
  logic [CNT_BITS-1:0] issue_cnt, issue_cnt_next;
  logic                rd_pend, rd_pend_next;
  logic [IDX_BITS-1:0] rd_slot, rd_slot_next;
  logic [IDX_BITS-1:0] hit_slot, hit_slot_next;
  logic                res_ok, res_ok_next;
  action_t             act, act_next;
  logic [KEY_BITS-1:0] key, key_next;

  ram_req_t            ram_req;
  logic [KEY_BITS-1:0] rd_data;
  logic                hit;
  logic [IDX_BITS-1:0] last_idx;
  logic                res_load;

  bst_entry_ram u_entry_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign item_ready = (state == S_IDLE);
  assign hit        = rd_pend && (rd_data == key);
  assign last_idx   = IDX_BITS'(fill_count - 1'b1);
  assign res_load   = (state == S_RESULT) && (!result_valid || result_ready);

  // sequencer: search, then write back where an add or a remove needs it; clear skips the search
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    issue_cnt_next  = issue_cnt;
    rd_pend_next    = 1'b0;
    rd_slot_next    = rd_slot;
    hit_slot_next   = hit_slot;
    res_ok_next     = res_ok;
    act_next        = act;
    key_next        = key;
    ram_req         = '0;
    ram_req.rd_addr = IDX_BITS'(issue_cnt);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          act_next       = action_t'(action);
          key_next       = value[KEY_BITS-1:0];
          issue_cnt_next = '0;
          if (action_t'(action) == ACT_CLEAR) begin
            fill_count_next = '0;
            res_ok_next     = 1'b1;
            state_next      = S_RESULT;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          // value found at rd_slot
          if (act == ACT_REMOVE) begin
            if (rd_slot == last_idx) begin
              fill_count_next = fill_count - 1'b1;
              res_ok_next     = 1'b1;
              state_next      = S_RESULT;
            end else begin
              hit_slot_next = rd_slot;
              state_next    = S_MOVE_RD;
            end
          end else begin
            res_ok_next = (act == ACT_TEST);
            state_next  = S_RESULT;
          end
        end else if (issue_cnt == fill_count) begin
          // every filled entry compared, no match
          res_ok_next = 1'b0;
          if (act == ACT_ADD && fill_count < CNT_BITS'(CAPACITY)) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = IDX_BITS'(fill_count);
            ram_req.wr_data = key;
            fill_count_next = fill_count + 1'b1;
            res_ok_next     = 1'b1;
          end
          state_next = S_RESULT;
        end else begin
          // issue the next entry read
          rd_pend_next   = 1'b1;
          rd_slot_next   = IDX_BITS'(issue_cnt);
          issue_cnt_next = issue_cnt + 1'b1;
        end
      end
      S_MOVE_RD: begin
        ram_req.rd_addr = last_idx;
        state_next      = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        // last entry fills the hole
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = hit_slot;
        ram_req.wr_data = rd_data;
        fill_count_next = fill_count - 1'b1;
        res_ok_next     = 1'b1;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (!result_valid || result_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rd_pend    <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      rd_pend    <= rd_pend_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    issue_cnt <= issue_cnt_next;
    rd_slot   <= rd_slot_next;
    hit_slot  <= hit_slot_next;
    res_ok    <= res_ok_next;
    act       <= act_next;
    key       <= key_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      ok          <= res_ok;
      entry_count <= COUNT_OUT_BITS'(fill_count);
      is_empty    <= (fill_count == '0);
    end
  end

endmodule

// ----- hw/rtl/bst_checker.sv -----
// port-level checks for the bounded set table, bound to the top level
// depends on bst_pkg and bounded_set_table
module bst_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic                               ok,
  input logic [bst_pkg::COUNT_OUT_BITS-1:0] entry_count,
  input logic                               is_empty
);
  import bst_pkg::*;

  // no result shows right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  // one item at a time: busy after an item transfer
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while previous item in work");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(ok) && $stable(entry_count) && $stable(is_empty)))
    else $error("stalled result changed");

endmodule

bind bounded_set_table bst_checker u_bst_checker (.*);

// ----- tb/bounded_set_table_test.sv -----
// testbench for bounded_set_table: directed and random add, remove, test and clear transfers
// checked against a scoreboard that keeps its own copy of the set; depends on bst_pkg
`timescale 1ns / 100ps

module bounded_set_table_test;
  import bst_pkg::*;

  localparam int RUN_LIMIT    = 800_000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int EPISODE_LEN  = 80;
  localparam int POOL_SIZE    = 20;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic                      ok;
    logic [COUNT_OUT_BITS-1:0] count;
    logic                      empty;
  } set_result_t;

  // set contents and pending results, updated at each accepted transfer
  class set_scoreboard;
    logic [KEY_BITS-1:0] held [CAPACITY];
    int                  held_count;
    set_result_t         expected [$];
    int                  errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    function void note_item(action_t act, logic [VALUE_BITS-1:0] v);
      logic [KEY_BITS-1:0] key;
      int                  slot;
      bit                  hit;
      set_result_t         r;
      key  = v[KEY_BITS-1:0];
      slot = 0;
      hit  = 1'b0;
      r.ok = 1'b0;
      // linear search over filled slots, first match wins
      for (int i = 0; i < held_count; i++) begin
        if (!hit && held[i] == key) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      case (act)
        ACT_ADD: begin
          if (!hit && held_count < CAPACITY) begin
            held[held_count] = key;
            held_count++;
            r.ok = 1'b1;
          end
        end
        ACT_REMOVE: begin
          // last entry moves into the freed slot
          if (hit) begin
            held[slot] = held[held_count-1];
            held_count--;
            r.ok = 1'b1;
          end
        end
        ACT_TEST: begin
          r.ok = hit;
        end
        default: begin
          held_count = 0;
          r.ok       = 1'b1;
        end
      endcase
      r.count = COUNT_OUT_BITS'(held_count);
      r.empty = (held_count == 0);
      expected.insert(expected.size(), r);
    endfunction

    function void check_result(logic ok_f, logic [COUNT_OUT_BITS-1:0] cnt, logic empty_f);
      set_result_t e;
      if (expected.size() == 0) begin
        $error("result transfer with no pending item: ok=%0d entry_count=%0d is_empty=%0d",
               ok_f, cnt, empty_f);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (ok_f !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, ok_f);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
      if (empty_f !== e.empty) begin
        $error("is_empty: expected %0d, got %0d", e.empty, empty_f);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      item_valid   = 1'b0;
  logic                      item_ready;
  logic [ACTION_BITS-1:0]    action       = '0;
  logic [VALUE_BITS-1:0]     value        = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic                      ok;
  logic [COUNT_OUT_BITS-1:0] entry_count;
  logic                      is_empty;

  set_scoreboard       sb = new();
  int                  cycles = 0;
  bit                  steady = 1'b0;
  logic [VALUE_BITS-1:0] pool [POOL_SIZE];

  bounded_set_table dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .value        (value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ok           (ok),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one item transfer; valid stays high if the next item follows without a gap
  task automatic send_item(action_t a, logic [VALUE_BITS-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= a;
    value      <= v;
    do @(posedge clk); while (!item_ready);
    sb.note_item(a, v);
  endtask

  // result side stalls
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result(ok, entry_count, is_empty);
    end
  end

  initial begin
    int      mode;
    int      r;
    int      w_add;
    int      w_rem;
    int      w_test;
    action_t act;
    logic [VALUE_BITS-1:0] v;

    pool[0] = '0;
    pool[1] = '1;
    pool[2] = 32'h8000_0000;
    pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = $urandom();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, duplicates, absent values, swap on remove, full set, clear
    send_item(ACT_REMOVE, 32'h0000_0000);
    send_item(ACT_ADD,    32'h0000_0000);
    send_item(ACT_ADD,    32'hFFFF_FFFF);
    send_item(ACT_ADD,    32'h0000_0000);
    send_item(ACT_TEST,   32'hFFFF_FFFF);
    send_item(ACT_TEST,   32'h0000_0005);
    send_item(ACT_REMOVE, 32'h0000_0005);
    send_item(ACT_REMOVE, 32'h0000_0000);
    send_item(ACT_TEST,   32'hFFFF_FFFF);
    for (int i = 0; i < CAPACITY - 1; i++) begin
      send_item(ACT_ADD, 32'h1000_0000 + i * 32'h0111_1111);
    end
    send_item(ACT_ADD,    32'hAAAA_AAAA);
    send_item(ACT_TEST,   32'h1000_0000 + (CAPACITY - 2) * 32'h0111_1111);
    send_item(ACT_REMOVE, 32'hFFFF_FFFF);
    send_item(ACT_CLEAR,  32'h5555_5555);
    send_item(ACT_CLEAR,  32'h0000_0000);

    // random episodes that grow, drain or churn the set
    mode   = 0;
    w_add  = 50;
    w_rem  = 20;
    w_test = 25;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % EPISODE_LEN == 0) begin
        mode   = $urandom_range(2);
        steady = ($urandom_range(3) == 0);
        case (mode)
          0:       begin w_add = 60; w_rem = 15; w_test = 22; end
          1:       begin w_add = 20; w_rem = 50; w_test = 27; end
          default: begin w_add = 35; w_rem = 30; w_test = 30; end
        endcase
      end
      r = $urandom_range(99);
      if (r < w_add) act = ACT_ADD;
      else if (r < w_add + w_rem) act = ACT_REMOVE;
      else if (r < w_add + w_rem + w_test) act = ACT_TEST;
      else act = ACT_CLEAR;
      if ($urandom_range(99) < 85) v = pool[$urandom_range(POOL_SIZE - 1)];
      else v = $urandom();
      send_item(act, v);
    end
    item_valid <= 1'b0;
    steady     = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
